// File: rtl/sapq_pkg.sv
// shared constants, codes and control structs for the sorted array priority queue
// no dependencies; imported by every module of the block
package sapq_pkg;

   // capacity and derived widths
   localparam int DEPTH     = 64;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int KEY_W     = 32;
   localparam int VALUE_W   = 32;
   localparam int CMD_W     = 3;
   localparam int POS_W     = 6;
   localparam int STATUS_W  = 2;
   localparam int ENTRY_COUNT_W = 7;
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_EXTRACT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MODIFY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_EXTRACT,
      OP_MARK,
      OP_BUBBLE,
      OP_CLEAR
   } dp_op_type;

   // controller to datapath
   typedef struct packed {
      dp_op_type             op;
      logic                  rsp_load;
      logic                  rsp_top;
      logic [STATUS_W-1:0]   rsp_status;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic pos_ok;
      logic moving;
   } dp_stat_type;

endpackage

// File: rtl/sorted_array_priority_queue_top.sv
// sorted array max priority queue, top level
// holds a DEPTH-entry key/value row kept in descending key order.
// req channel: cmd (insert, extract max, peek max, modify key, clear),
//   in_key, in_value, position; a transfer happens when req_valid and
//   req_ready are both high.
// rsp channel: status, out_key, out_value, entry_count, one response per
//   request, in request order, through a response register.
// insert, extract, peek, clear, unused codes and an out-of-range modify finish
//   in the cycle they are taken: the response shows the next cycle, one
//   request per cycle while responses are read. modify writes the new key
//   into its cell, then moves the entry one place per cycle by an adjacent
//   compare-and-swap across the row until it settles.
// req_ready drops while a modify is moving and while an unread response is
//   held and rsp_ready is low; a stalled receiver thus holds the queue.
// reset (synchronous) empties the queue and drops rsp_valid; cell keys and
//   values are not cleared, only the count and the modify marks.
// depends on sapq_pkg, sapq_ctrl, sapq_datapath
module sorted_array_priority_queue_top
   import sapq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [KEY_W-1:0]    req_in_key,
   input  logic [VALUE_W-1:0]         req_in_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [KEY_W-1:0]    rsp_out_key,
   output logic [VALUE_W-1:0]         rsp_out_value,
   output logic [ENTRY_COUNT_W-1:0]   rsp_entry_count
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // control
   sapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   // storage and compare row
   sapq_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_stat         (dp_stat),
      .in_key          (req_in_key),
      .in_value        (req_in_value),
      .position        (req_position),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_value   (rsp_out_value),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// File: rtl/sapq_ctrl.sv
// controller state machine: handshakes, command decode, modify sequencing
// depends on sapq_pkg
module sapq_ctrl
   import sapq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dp_cmd_type        dp_cmd,
   input  dp_stat_type       dp_stat
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_MOVE = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // take a request only in idle and when the response slot is free or being freed
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // decode
   always_comb begin
      state_in          = state_ff;
      dp_cmd.op         = OP_NONE;
      dp_cmd.rsp_load   = 1'b0;
      dp_cmd.rsp_top    = 1'b0;
      dp_cmd.rsp_status = STATUS_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dp_cmd.rsp_load = 1'b1;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     if (dp_stat.full) begin
                        dp_cmd.rsp_status = STATUS_FULL;
                     end else begin
                        dp_cmd.op = OP_INSERT;
                     end
                  end
                  CMD_EXTRACT: begin
                     if (dp_stat.empty) begin
                        dp_cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        dp_cmd.op      = OP_EXTRACT;
                        dp_cmd.rsp_top = 1'b1;
                     end
                  end
                  CMD_PEEK: begin
                     if (dp_stat.empty) begin
                        dp_cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        dp_cmd.rsp_top = 1'b1;
                     end
                  end
                  CMD_MODIFY: begin
                     if (!dp_stat.pos_ok) begin
                        dp_cmd.rsp_status = STATUS_RANGE;
                     end else begin
                        dp_cmd.op       = OP_MARK;
                        dp_cmd.rsp_load = 1'b0;
                        state_in        = S_MOVE;
                     end
                  end
                  CMD_CLEAR: begin
                     dp_cmd.op = OP_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MOVE: begin
            // walk the modified entry one place a cycle until it settles
            if (dp_stat.moving) begin
               dp_cmd.op = OP_BUBBLE;
            end else begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      priority if (dp_cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/sapq_datapath.sv
// datapath: row of sorted key/value cells with parallel compare-and-shift,
// entry count and response registers; depends on sapq_pkg
module sapq_datapath
   import sapq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 dp_cmd,
   output dp_stat_type                dp_stat,
   input  logic signed [KEY_W-1:0]    in_key,
   input  logic [VALUE_W-1:0]         in_value,
   input  logic [POS_W-1:0]           position,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [KEY_W-1:0]    rsp_out_key,
   output logic [VALUE_W-1:0]         rsp_out_value,
   output logic [ENTRY_COUNT_W-1:0]   rsp_entry_count
);

   logic signed [KEY_W-1:0] key_ff   [DEPTH];
   logic signed [KEY_W-1:0] key_in   [DEPTH];
   logic [VALUE_W-1:0]      value_ff [DEPTH];
   logic [VALUE_W-1:0]      value_in [DEPTH];
   logic [DEPTH-1:0]        mark_ff, mark_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   // neighbor views per cell
   logic signed [KEY_W-1:0] lo_key   [DEPTH];
   logic signed [KEY_W-1:0] hi_key   [DEPTH];
   logic [VALUE_W-1:0]      lo_value [DEPTH];
   logic [VALUE_W-1:0]      hi_value [DEPTH];
   logic [DEPTH-1:0]        lo_mark, hi_mark;
   logic [DEPTH-1:0]        valid, ge, lo_ge, sel;
   logic [DEPTH-1:0]        swap_lo, swap_hi;
   logic [DEPTH-2:0]        swap;

   logic [STATUS_W-1:0]      rsp_status_ff;
   logic signed [KEY_W-1:0]  rsp_key_ff;
   logic [VALUE_W-1:0]       rsp_value_ff;
   logic [CNT_W-1:0]         rsp_count_ff;

   // per-cell compares against the request and the count
   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      assign valid[i] = CNT_W'(i) < count_ff;
      assign ge[i]    = valid[i] && !(in_key > key_ff[i]);
      assign sel[i]   = CMP_W'(position) == CMP_W'(i);
   end

   // adjacent pair swaps for moving a modified entry up or down
   for (genvar j = 0; j < DEPTH - 1; j++) begin : g_pair
      logic up_sw, dn_sw;
      assign up_sw   = mark_ff[j+1] && (key_ff[j+1] > key_ff[j]);
      assign dn_sw   = mark_ff[j] && valid[j+1] && !(key_ff[j] > key_ff[j+1]);
      assign swap[j] = up_sw || dn_sw;
   end

   // neighbor wiring, edges tied off
   for (genvar i = 0; i < DEPTH; i++) begin : g_nbr
      if (i == 0) begin : g_first
         assign lo_key[i]   = key_ff[i];
         assign lo_value[i] = value_ff[i];
         assign lo_mark[i]  = mark_ff[i];
         assign lo_ge[i]    = 1'b1;
         assign swap_lo[i]  = 1'b0;
      end else begin : g_mid_lo
         assign lo_key[i]   = key_ff[i-1];
         assign lo_value[i] = value_ff[i-1];
         assign lo_mark[i]  = mark_ff[i-1];
         assign lo_ge[i]    = ge[i-1];
         assign swap_lo[i]  = swap[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign hi_key[i]   = key_ff[i];
         assign hi_value[i] = value_ff[i];
         assign hi_mark[i]  = mark_ff[i];
         assign swap_hi[i]  = 1'b0;
      end else begin : g_mid_hi
         assign hi_key[i]   = key_ff[i+1];
         assign hi_value[i] = value_ff[i+1];
         assign hi_mark[i]  = mark_ff[i+1];
         assign swap_hi[i]  = swap[i];
      end
   end

   // cell next state
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_comb begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         mark_in[i]  = mark_ff[i];
         unique case (dp_cmd.op)
            OP_INSERT: begin
               if (!ge[i]) begin
                  if (lo_ge[i]) begin
                     key_in[i]   = in_key;
                     value_in[i] = in_value;
                  end else begin
                     key_in[i]   = lo_key[i];
                     value_in[i] = lo_value[i];
                  end
               end
            end
            OP_EXTRACT: begin
               key_in[i]   = hi_key[i];
               value_in[i] = hi_value[i];
            end
            OP_MARK: begin
               mark_in[i] = sel[i];
               if (sel[i]) begin
                  key_in[i] = in_key;
               end
            end
            OP_BUBBLE: begin
               priority if (swap_hi[i]) begin
                  key_in[i]   = hi_key[i];
                  value_in[i] = hi_value[i];
                  mark_in[i]  = hi_mark[i];
               end else if (swap_lo[i]) begin
                  key_in[i]   = lo_key[i];
                  value_in[i] = lo_value[i];
                  mark_in[i]  = lo_mark[i];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // entry count
   always_comb begin
      unique case (dp_cmd.op)
         OP_INSERT:  count_in = count_ff + CNT_W'(1);
         OP_EXTRACT: count_in = count_ff - CNT_W'(1);
         OP_CLEAR:   count_in = '0;
         default:    count_in = count_ff;
      endcase
   end

   // status back to the controller
   assign dp_stat.empty  = (count_ff == '0);
   assign dp_stat.full   = (count_ff >= CNT_W'(DEPTH));
   assign dp_stat.pos_ok = CMP_W'(position) < CMP_W'(count_ff);
   assign dp_stat.moving = |swap;

   // cell storage
   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         key_ff[k]   <= key_in[k];
         value_ff[k] <= value_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff  <= '0;
         count_ff <= '0;
      end else begin
         mark_ff  <= mark_in;
         count_ff <= count_in;
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      if (dp_cmd.rsp_load) begin
         rsp_status_ff <= dp_cmd.rsp_status;
         rsp_key_ff    <= dp_cmd.rsp_top ? key_ff[0] : '0;
         rsp_value_ff  <= dp_cmd.rsp_top ? value_ff[0] : '0;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_entry_count = ENTRY_COUNT_W'(rsp_count_ff);

endmodule

// File: rtl/sapq_checker.sv
// port-level checks for the sorted array priority queue, bound to the top level
// depends on sapq_pkg and sorted_array_priority_queue_top
module sapq_checker
   import sapq_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [CMD_W-1:0]           req_cmd,
   input logic signed [KEY_W-1:0]    req_in_key,
   input logic [VALUE_W-1:0]         req_in_value,
   input logic [POS_W-1:0]           req_position,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [STATUS_W-1:0]        rsp_status,
   input logic signed [KEY_W-1:0]    rsp_out_key,
   input logic [VALUE_W-1:0]         rsp_out_value,
   input logic [ENTRY_COUNT_W-1:0]   rsp_entry_count
);

   // reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a clear transfer answers next cycle with an empty queue
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == CMD_CLEAR)
      |=> (rsp_valid && rsp_status == STATUS_OK && rsp_entry_count == '0))
      else $error("clear did not answer with an empty queue");

   // empty status only with no entries held
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_entry_count == '0))
      else $error("empty status with entries held");

   // full status only at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL)
      |-> (rsp_entry_count == ENTRY_COUNT_W'(DEPTH)))
      else $error("full status below capacity");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready)
      |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_out_key)
           && $stable(rsp_out_value) && $stable(rsp_entry_count)))
      else $error("stalled response changed");

endmodule

bind sorted_array_priority_queue_top sapq_checker u_sapq_checker (.*);
